// File: design/cmpr_pkg.sv
// Shared types, constants and register codes for the console mouse poll responder.
// Used by every module under design/; depends on nothing else.
package cmpr_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int MOVE_W = 16;
  localparam int SENS_W = 10;
  localparam int LIM_W  = 7;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Protocol bytes.
  localparam logic [BYTE_W-1:0] CMD_POLL    = 8'h42;
  localparam logic [BYTE_W-1:0] REPLY_ID    = 8'h12;
  localparam logic [BYTE_W-1:0] REPLY_ID_HI = 8'h5A;
  localparam logic [BYTE_W-1:0] REPLY_IDLE  = 8'hFF;
  localparam logic [BYTE_W-1:0] BTN_IDLE    = 8'hFC;

  // Active-low button bit positions.
  localparam int BTN_MIDDLE_BIT = 7;
  localparam int BTN_WHEEL_UP   = 6;
  localparam int BTN_WHEEL_DOWN = 5;
  localparam int BTN_LEFT_BIT   = 3;
  localparam int BTN_RIGHT_BIT  = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSITIVITY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_LIMIT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_ZONE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXT_BUTTONS   = 2'd3;
  localparam int CFG_DATA_W = SENS_W;

  // Register reset values.
  localparam logic [SENS_W-1:0] SENS_RESET  = 10'd100;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 7'd127;
  localparam logic [LIM_W-1:0]  DEAD_RESET  = 7'd0;

  // Division by 100 as a reciprocal multiply. Exact for dividends below 12800,
  // which covers every value that is not clamped by the movement limit.
  localparam int               QIN_W        = 14;
  localparam logic [QIN_W-1:0] PERCENT      = 14'd100;
  localparam logic [QIN_W-1:0] DIV100_RECIP = 14'd10486;
  localparam int               DIV100_SHIFT = 20;

  // Position of a byte within the six-byte reply.
  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] POS_ID    = 3'd0;
  localparam logic [POS_W-1:0] POS_ID_HI = 3'd1;
  localparam logic [POS_W-1:0] POS_PAD   = 3'd2;
  localparam logic [POS_W-1:0] POS_BTN   = 3'd3;
  localparam logic [POS_W-1:0] POS_X     = 3'd4;
  localparam logic [POS_W-1:0] POS_Y     = 3'd5;

  // One classified poll start, as it waits in the queue.
  typedef struct packed {
    logic                     is_poll;
    logic [BYTE_W-1:0]        buttons;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
  } cmpr_entry_t;

  // Movement shaping settings.
  typedef struct packed {
    logic [SENS_W-1:0] sens;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  dead;
  } cmpr_cfg_t;

endpackage

// File: design/cmpr_front.sv
// Front part of the poll responder: accepts input items, drops non-start items,
// classifies the command and builds the button byte. Depends on cmpr_pkg.
module cmpr_front import cmpr_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BYTE_W-1:0]        command,
  input  logic                     starts_poll,
  input  logic signed [MOVE_W-1:0] move_x,
  input  logic signed [MOVE_W-1:0] move_y,
  input  logic signed [BYTE_W-1:0] wheel,
  input  logic                     left_button,
  input  logic                     right_button,
  input  logic                     middle_button,
  input  logic                     ext_buttons,
  input  logic                     full,
  output logic                     push,
  output cmpr_entry_t              entry
);

  logic [BYTE_W-1:0] buttons;

  always_comb begin
    buttons = BTN_IDLE;
    if (left_button)  buttons[BTN_LEFT_BIT]  = 1'b0;
    if (right_button) buttons[BTN_RIGHT_BIT] = 1'b0;
    if (ext_buttons) begin
      if (middle_button) buttons[BTN_MIDDLE_BIT] = 1'b0;
      if (wheel > 0)     buttons[BTN_WHEEL_UP]   = 1'b0;
      if (wheel < 0)     buttons[BTN_WHEEL_DOWN] = 1'b0;
    end
  end

  assign in_ready = !full;
  // Items that do not start a transaction are taken and dropped.
  assign push     = in_valid && !full && starts_poll;

  assign entry.is_poll = (command == CMD_POLL);
  assign entry.buttons = buttons;
  assign entry.move_x  = move_x;
  assign entry.move_y  = move_y;

endmodule

// File: design/cmpr_queue.sv
// Small FIFO of classified poll starts between the front and the back.
// Depends on cmpr_pkg for the entry type.
module cmpr_queue import cmpr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cmpr_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output cmpr_entry_t pop_data,
  output logic        empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmpr_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: design/cmpr_shape.sv
// Three-stage movement shaper for one axis: scale, divide by 100, saturate,
// clamp to the limit and apply the dead zone. Depends on cmpr_pkg.
module cmpr_shape import cmpr_pkg::*; (
  input  logic                     clk,
  input  logic signed [MOVE_W-1:0] raw,
  input  cmpr_cfg_t                cfg,
  output logic [BYTE_W-1:0]        shaped
);

  localparam int PROD_W = MOVE_W + SENS_W + 1;
  localparam int MAG_W  = PROD_W - 1;
  localparam int QP_W   = 2 * QIN_W;

  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag_full;
  logic [MAG_W-1:0]         mag;
  logic [QIN_W-1:0]         limit_x100;
  logic                     neg_s2;
  logic                     sat_s2;
  logic [QIN_W-1:0]         mag_low_s2;
  logic [QP_W-1:0]          qprod;
  logic                     neg_s3;
  logic [LIM_W-1:0]         mag_s3;
  logic [BYTE_W-1:0]        mag_byte;

  // Stage 1: scale by the sensitivity.
  always_ff @(posedge clk) begin
    prod <= raw * $signed({1'b0, cfg.sens});
  end

  // Stage 2: magnitude, and whether the quotient reaches the limit.
  // A quotient past the signed-byte range is always at or above the limit,
  // since the limit is at most 127, so one compare covers both.
  assign mag_full   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign mag        = mag_full[MAG_W-1:0];
  assign limit_x100 = QIN_W'(cfg.limit) * PERCENT;

  always_ff @(posedge clk) begin
    neg_s2     <= prod[PROD_W-1];
    sat_s2     <= (mag >= MAG_W'(limit_x100));
    mag_low_s2 <= mag[QIN_W-1:0];
  end

  // Stage 3: quotient by reciprocal, then the clamp.
  assign qprod = QP_W'(mag_low_s2) * QP_W'(DIV100_RECIP);

  always_ff @(posedge clk) begin
    neg_s3 <= neg_s2;
    mag_s3 <= sat_s2 ? cfg.limit : qprod[DIV100_SHIFT +: LIM_W];
  end

  assign mag_byte = {1'b0, mag_s3};

  always_comb begin
    if (mag_s3 <= cfg.dead) shaped = '0;
    else if (neg_s3)        shaped = ~mag_byte + 1'b1;
    else                    shaped = mag_byte;
  end

endmodule

// File: design/cmpr_back.sv
// Back part of the poll responder: takes entries from the queue, shapes the
// movement and sends the six reply bytes. Depends on cmpr_pkg and cmpr_shape.
module cmpr_back import cmpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmpr_cfg_t         cfg,
  input  logic              empty,
  input  cmpr_entry_t       pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  cmpr_entry_t       cur;
  logic              busy;
  logic [POS_W-1:0]  pos;
  logic              out_fire;
  logic [BYTE_W-1:0] x_byte;
  logic [BYTE_W-1:0] y_byte;

  cmpr_shape u_shape_x (
    .clk    (clk),
    .raw    (cur.move_x),
    .cfg    (cfg),
    .shaped (x_byte)
  );

  cmpr_shape u_shape_y (
    .clk    (clk),
    .raw    (cur.move_y),
    .cfg    (cfg),
    .shaped (y_byte)
  );

  assign out_valid = busy;
  assign out_last  = (pos == POS_Y);
  assign out_fire  = busy && out_ready;
  // The next entry is loaded at the edge that sends the last byte.
  assign pop       = !empty && (!busy || (out_fire && out_last));

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_ID;
    end else if (pop) begin
      busy <= 1'b1;
      pos  <= POS_ID;
    end else if (out_fire) begin
      if (out_last) busy <= 1'b0;
      else          pos  <= pos + 1'b1;
    end
  end

  always_comb begin
    case (pos)
      POS_ID:    out_byte = REPLY_ID;
      POS_ID_HI: out_byte = cur.is_poll ? REPLY_ID_HI : REPLY_IDLE;
      POS_PAD:   out_byte = REPLY_IDLE;
      POS_BTN:   out_byte = cur.is_poll ? cur.buttons : REPLY_IDLE;
      POS_X:     out_byte = cur.is_poll ? x_byte : REPLY_IDLE;
      POS_Y:     out_byte = cur.is_poll ? y_byte : REPLY_IDLE;
      default:   out_byte = REPLY_IDLE;
    endcase
  end

endmodule

// File: design/console_mouse_poll_response.sv
// Top level of the console mouse poll responder: configuration registers and
// the front, queue and back. Depends on cmpr_pkg and all cmpr_* modules.
//
// Every input item that starts a transaction is answered with six reply bytes
// on the master stream, the sixth marked by m_tlast; items that do not start a
// transaction are taken and dropped. A poll command answers with the ID bytes,
// a pad byte, the active-low button byte and the shaped X and Y movement; any
// other command answers with the first ID byte and five idle bytes. The first
// reply byte is offered once its item has passed the queue and been loaded into
// the back's current-entry register. The back sends one byte per cycle while
// m_tready is high and loads the next waiting entry with the last byte, so the
// replies to a steady stream of poll starts follow back to back, paced by the
// six-byte reply serializer. A queue of QUEUE_DEPTH entries sits between the
// front and the back, so the slave side keeps taking items while a reply is
// still being sent or is stalled, until the queue is full. The movement shaper
// is a three-stage pipeline per axis that finishes before the X byte comes up.
// The configuration port is always ready and should only be written while no reply is pending.
module console_mouse_poll_response import cmpr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input items.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // From bit 0: command[7:0], move_x[23:8], move_y[39:24], wheel[47:40],
  // left_button[48], right_button[49], middle_button[50], zero[55:51].
  input  logic [55:0]            s_tdata,
  // Bit 0: starts_poll.
  input  logic                   s_tuser,
  // Result items.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // From bit 0: response_byte[7:0].
  output logic [BYTE_W-1:0]      m_tdata,
  // is_last.
  output logic                   m_tlast,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmpr_cfg_t   cfg;
  logic        ext_buttons;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  cmpr_entry_t push_data;
  cmpr_entry_t pop_data;

  // Configuration registers. Only the low bits of each register's width are
  // kept from the write data.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sens    <= SENS_RESET;
      cfg.limit   <= LIMIT_RESET;
      cfg.dead    <= DEAD_RESET;
      ext_buttons <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSITIVITY: cfg.sens    <= cfg_data[SENS_W-1:0];
        REG_MOVE_LIMIT:  cfg.limit   <= cfg_data[LIM_W-1:0];
        REG_DEAD_ZONE:   cfg.dead    <= cfg_data[LIM_W-1:0];
        REG_EXT_BUTTONS: ext_buttons <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cmpr_front u_front (
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .command       (s_tdata[7:0]),
    .starts_poll   (s_tuser),
    .move_x        (s_tdata[23:8]),
    .move_y        (s_tdata[39:24]),
    .wheel         (s_tdata[47:40]),
    .left_button   (s_tdata[48]),
    .right_button  (s_tdata[49]),
    .middle_button (s_tdata[50]),
    .ext_buttons   (ext_buttons),
    .full          (full),
    .push          (push),
    .entry         (push_data)
  );

  cmpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cmpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // A reply is never cut short: after a byte that is not the last, another
  // byte of the same reply is offered.
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("reply interrupted before its last byte");

  // A reply that follows another one starts with the ID byte.
  a_reply_starts_with_id: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata == REPLY_ID))
    else $error("reply does not start with the ID byte");

  // Nothing is offered right after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");
`endif

endmodule

// File: verif/mouse_reply_checker.sv
// Reply checker for the console mouse poll responder: watches the item, reply and
// register-write channels, predicts each six-byte reply and compares it byte by byte.
// Depends on cmpr_pkg for the protocol bytes, button bit positions and register codes.
module mouse_reply_checker import cmpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [55:0]            s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [BYTE_W-1:0]      m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     outstanding
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } reply_byte_t;

  reply_byte_t       pending_reply[$];
  logic [SENS_W-1:0] sens_pct;
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  dead;
  logic              ext_buttons;
  logic [BYTE_W-1:0] latched_cmd;
  logic              config_mode;
  int                byte_count;

  function automatic logic [BYTE_W-1:0] shape_move(logic signed [MOVE_W-1:0] raw);
    int scaled;
    int lim;
    int dz;
    scaled = (int'(raw) * int'(sens_pct)) / 100;
    lim = int'(limit);
    dz  = int'(dead);
    if (scaled < -128) scaled = -128;
    if (scaled > 127) scaled = 127;
    if (scaled > lim) scaled = lim;
    if (scaled < -lim) scaled = -lim;
    if (scaled >= -dz && scaled <= dz) scaled = 0;
    return scaled[BYTE_W-1:0];
  endfunction

  task automatic predict_reply(logic [55:0] item);
    logic [BYTE_W-1:0]        reply[6];
    logic [BYTE_W-1:0]        btn;
    logic signed [BYTE_W-1:0] whl;
    latched_cmd = item[7:0];
    whl = item[47:40];
    if (latched_cmd == CMD_POLL) begin
      config_mode = 1'b0;
      btn = BTN_IDLE;
      if (item[48]) btn[BTN_LEFT_BIT] = 1'b0;
      if (item[49]) btn[BTN_RIGHT_BIT] = 1'b0;
      if (ext_buttons) begin
        if (item[50]) btn[BTN_MIDDLE_BIT] = 1'b0;
        if (whl > 0) btn[BTN_WHEEL_UP] = 1'b0;
        if (whl < 0) btn[BTN_WHEEL_DOWN] = 1'b0;
      end
      reply[0] = REPLY_ID;
      reply[1] = REPLY_ID_HI;
      reply[2] = REPLY_IDLE;
      reply[3] = btn;
      reply[4] = shape_move(item[23:8]);
      reply[5] = shape_move(item[39:24]);
    end else begin
      reply[0] = REPLY_ID;
      for (int k = 1; k < 6; k++) reply[k] = REPLY_IDLE;
    end
    for (int k = 0; k < 6; k++) pending_reply.push_back('{reply[k], k == 5});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sens_pct    = SENS_RESET;
      limit       = LIMIT_RESET;
      dead        = DEAD_RESET;
      ext_buttons = 1'b0;
      latched_cmd = '0;
      config_mode = 1'b0;
      pending_reply.delete();
      failures    = 0;
      byte_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENSITIVITY: sens_pct    = cfg_data[SENS_W-1:0];
          REG_MOVE_LIMIT:  limit       = cfg_data[LIM_W-1:0];
          REG_DEAD_ZONE:   dead        = cfg_data[LIM_W-1:0];
          REG_EXT_BUTTONS: ext_buttons = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready && s_tuser) predict_reply(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_reply.size() == 0) begin
          $display("%0t: unexpected reply byte %02h last %0b, none expected",
                   $time, m_tdata, m_tlast);
          failures++;
        end else begin
          reply_byte_t want;
          want = pending_reply.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.last) begin
            $display("%0t: reply byte %0d expected %02h last %0b, got %02h last %0b",
                     $time, byte_count, want.value, want.last, m_tdata, m_tlast);
            failures++;
          end
        end
        byte_count++;
      end
    end
    outstanding <= rst ? 0 : pending_reply.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the console mouse poll responder testbench: clock, reset, item and register
// stimulus, random back-pressure, watchdog and verdict. Depends on cmpr_pkg, the
// block console_mouse_poll_response and the reply checker mouse_reply_checker.
module testbench;
  import cmpr_pkg::*;

  // Cycles without any handshake on any channel before the run is declared hung. A correct
  // run never comes close: a reply byte is waiting out at most a handful of stalls.
  localparam int WATCHDOG_LIMIT = 4000;
  // The first reply byte comes out once its item has passed the queue and the back's
  // entry register, so this margin is plenty for anything still moving inside the block to come out.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 26;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [55:0]            s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [BYTE_W-1:0]      m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int   failures;
  int   outstanding;
  int   quiet_cycles = 0;
  // While calm is set neither side idles, which gives one long stretch at full rate.
  logic calm = 1'b0;

  console_mouse_poll_response dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mouse_reply_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .failures(failures), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The reply side stalls at random, about 28 percent of the time, except while calm.
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
  end

  // The watchdog restarts whenever any channel moves an item or a register write.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Packs the item fields from bit 0 up: command, move_x, move_y, wheel and the
  // left, right and middle buttons, with the top five bits left at zero.
  function automatic logic [55:0] pack_item(logic [7:0] cmd, logic [15:0] mx,
                                            logic [15:0] my, logic [7:0] whl,
                                            logic left, logic right, logic middle);
    return {5'b0, middle, right, left, whl, my, mx, cmd};
  endfunction

  // Offers one item and returns at the edge that accepts it, with tvalid still
  // high. Before the offer the sender idles a random number of cycles unless calm.
  task automatic send_item(logic [55:0] item, logic start);
    while (!calm && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_poll(logic [7:0] cmd, logic signed [15:0] mx, logic signed [15:0] my,
                           logic signed [7:0] whl, logic left, logic right, logic middle);
    send_item(pack_item(cmd, mx, my, whl, left, right, middle), 1'b1);
  endtask

  // Lowers tvalid and waits until every predicted reply byte has come out, then
  // lets the block run empty for a few more cycles. The first edge lets the
  // checker's count catch up with an item accepted at the current edge.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four registers. The narrow registers get the given upper bits
  // above their value, which the block has to ignore.
  task automatic load_settings(logic [9:0] sens, logic [6:0] lim, logic [6:0] dz, logic ext,
                               logic [9:0] junk);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_MOVE_LIMIT, {junk[9:7], lim});
    write_reg(REG_DEAD_ZONE, {junk[6:4], dz});
    write_reg(REG_EXT_BUTTONS, {junk[8:0], ext});
  endtask

  // Half of the movement values are small, so that scaling, limiting and the dead
  // zone all matter; full-range values and the extremes make up the rest.
  function automatic logic [15:0] rand_move();
    case ($urandom_range(3))
      0: return 16'($urandom_range(400)) - 16'd200;
      1: return 16'($urandom());
      2: return 16'($urandom_range(4000)) - 16'd2000;
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [9:0] rand_sensitivity();
    case ($urandom_range(9))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'd1000;
      3: return 10'($urandom_range(1023));
      default: return 10'($urandom_range(250));
    endcase
  endfunction

  // One random phase: random settings, then a run of items. Most are well-formed
  // polls; the rest are other commands and items that do not start a transaction.
  task automatic random_phase();
    logic [6:0] lim;
    logic [6:0] dz;
    int         counted;
    int         pick;
    logic [7:0] cmd;
    lim = ($urandom_range(4) == 0) ? 7'($urandom_range(1) * 127) : 7'($urandom_range(127));
    dz  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(lim / 3));
    load_settings(rand_sensitivity(), lim, dz, 1'($urandom_range(1)), 10'($urandom()));
    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // Ignored by the block, so it does not count toward the phase.
        cmd = ($urandom_range(1) == 0) ? CMD_POLL : 8'($urandom());
        send_item(pack_item(cmd, 16'($urandom()), 16'($urandom()), 8'($urandom()),
                            1'($urandom()), 1'($urandom()), 1'($urandom())), 1'b0);
      end else begin
        cmd = (pick < 25) ? 8'($urandom()) : CMD_POLL;
        send_poll(cmd, rand_move(), rand_move(), 8'($urandom()),
                  1'($urandom()), 1'($urandom()), 1'($urandom()));
        counted++;
      end
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: full scale, full limit, no dead zone, plain buttons.
    send_poll(CMD_POLL, 16'sd0, 16'sd0, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_poll(CMD_POLL, 16'sd0, 16'sd0, 8'sd0, 1'b1, 1'b0, 1'b0);
    // Middle button and wheel must not show while the extended bits are off.
    send_poll(CMD_POLL, 16'sd0, 16'sd0, 8'sd1, 1'b0, 1'b1, 1'b1);
    send_poll(CMD_POLL, 16'sd32767, -16'sd32768, -8'sd128, 1'b1, 1'b1, 1'b1);
    send_poll(CMD_POLL, -16'sd32768, 16'sd32767, 8'sd127, 1'b0, 1'b0, 1'b0);
    send_poll(CMD_POLL, 16'sd1, -16'sd1, 8'sd0, 1'b0, 1'b0, 1'b0);
    // Commands other than poll data answer with the ID and idle bytes.
    send_poll(8'h00, 16'sd5, 16'sd5, 8'sd0, 1'b1, 1'b1, 1'b1);
    send_poll(8'hff, -16'sd5, -16'sd5, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_poll(8'h43, 16'sd100, 16'sd100, 8'sd3, 1'b1, 1'b0, 1'b1);
    // Items that do not start a transaction are dropped without a reply.
    send_item(pack_item(CMD_POLL, 16'h1234, 16'h8765, 8'h80, 1'b1, 1'b1, 1'b1), 1'b0);
    send_item(pack_item(8'h12, 16'hffff, 16'h0000, 8'h7f, 1'b0, 1'b1, 1'b0), 1'b0);
    settle();

    // Sensitivity above 1000 with extended buttons on.
    load_settings(10'd1023, 7'd127, 7'd0, 1'b1, 10'd0);
    send_poll(CMD_POLL, 16'sd0, 16'sd0, 8'sd127, 1'b1, 1'b1, 1'b1);
    send_poll(CMD_POLL, 16'sd12, -16'sd13, -8'sd128, 1'b0, 1'b0, 1'b1);
    send_poll(CMD_POLL, 16'sd32767, -16'sd32768, 8'sd0, 1'b1, 1'b0, 1'b0);
    send_poll(CMD_POLL, 16'sd13, -16'sd12, -8'sd1, 1'b0, 1'b1, 1'b0);
    settle();

    // Zero scale, zero limit and the widest dead zone. The extended flag is
    // written with every upper bit set, which must be ignored.
    load_settings(10'd0, 7'd0, 7'd127, 1'b0, 10'h3ff);
    send_poll(CMD_POLL, 16'sd32767, -16'sd32768, 8'sd5, 1'b1, 1'b1, 1'b1);
    send_poll(8'h41, 16'sd32767, -16'sd32768, 8'sd5, 1'b1, 1'b1, 1'b1);
    settle();

    // Ten times scale with a limit of 50 and a dead zone of 10, so that values
    // land on both sides of each boundary, the dead zone edge itself included.
    load_settings(10'd1000, 7'd50, 7'd10, 1'b1, 10'h2a5);
    send_poll(CMD_POLL, 16'sd5, -16'sd5, 8'sd0, 1'b0, 1'b0, 1'b0);
    send_poll(CMD_POLL, 16'sd1, -16'sd1, 8'sd2, 1'b0, 1'b0, 1'b0);
    send_poll(CMD_POLL, 16'sd2, -16'sd2, -8'sd2, 1'b1, 1'b1, 1'b0);
    send_poll(CMD_POLL, -16'sd7, 16'sd7, 8'sd0, 1'b0, 1'b0, 1'b1);
    settle();

    // Random phases, one of them without any idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm = (phase == 3);
      random_phase();
    end
    calm = 1'b0;

    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/cmpr_pkg.sv
design/cmpr_front.sv
design/cmpr_queue.sv
design/cmpr_shape.sv
design/cmpr_back.sv
design/console_mouse_poll_response.sv
verif/mouse_reply_checker.sv
verif/testbench.sv
